// ----- sv/fat12_cluster_chain_walker_assert.svh -----
// ---------------------------------------------------------------------------
// FAT12 chain walker assertion macros
// Concurrent check wrappers; defining NO_ASSERTIONS removes them.
// ---------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_WALKER_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Implication in the same cycle, checked out of reset.
`define FCCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the following cycle, checked out of reset.
`define FCCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FCCW_ASSERT_NOW(label, ante, cons, msg)
`define FCCW_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- sv/fccw_pkg.sv -----
// ---------------------------------------------------------------------------
// FAT12 chain walker package
// Shared sizes, request kinds and controller states.
// ---------------------------------------------------------------------------
package fccw_pkg;

  localparam int TABLE_ENTRIES   = 4096;
  localparam int CLUSTER_BYTES   = 512;
  localparam int TBL_AW          = $clog2(TABLE_ENTRIES);
  localparam int POS_W           = TBL_AW + 1;
  localparam int CLUSTER_SHIFT   = $clog2(CLUSTER_BYTES);

  localparam int LINK_W          = 12;
  localparam int KIND_W          = 2;
  localparam int BYTE_W          = 8;
  localparam int SIZE_W          = 22;
  localparam int ADDR_W          = 32;
  localparam int LEN_W           = 10;
  localparam int HELD_W          = 16;

  localparam logic [ADDR_W-1:0] DATA_BASE_RESET = 32'h0000_3e00;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_NEXT  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    LD_FIRST  = 2'd0,
    LD_SECOND = 2'd1,
    LD_THIRD  = 2'd2
  } load_phase_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LINK = 1'b1
  } state_t;

endpackage

// ----- sv/fccw_in_if.sv -----
// ---------------------------------------------------------------------------
// FAT12 chain walker request channel
// Valid/ready channel carrying load, start and next-chunk requests.
// ---------------------------------------------------------------------------
interface fccw_in_if
  import fccw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] packed_byte;
  logic              restart_load;
  logic [LINK_W-1:0] start_cluster;
  logic [SIZE_W-1:0] byte_size;

  modport source (
    output valid, kind, packed_byte, restart_load, start_cluster, byte_size,
    input  ready
  );

  modport sink (
    input  valid, kind, packed_byte, restart_load, start_cluster, byte_size,
    output ready
  );
endinterface

// ----- sv/fccw_out_if.sv -----
// ---------------------------------------------------------------------------
// FAT12 chain walker descriptor channel
// Valid/ready channel carrying one chunk descriptor per chunk request.
// ---------------------------------------------------------------------------
interface fccw_out_if
  import fccw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [LINK_W-1:0] cluster;
  logic [ADDR_W-1:0] byte_address;
  logic [LEN_W-1:0]  chunk_length;
  logic              last_chunk;
  logic              chain_error;

  modport source (
    output valid, cluster, byte_address, chunk_length, last_chunk, chain_error,
    input  ready
  );

  modport sink (
    input  valid, cluster, byte_address, chunk_length, last_chunk, chain_error,
    output ready
  );
endinterface

// ----- sv/fccw_ram.sv -----
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module fccw_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/fat12_cluster_chain_walker.sv -----
// ---------------------------------------------------------------------------
// FAT12 cluster chain walker
// Loads a packed 12-bit allocation table and walks cluster chains.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : requests. kind LOAD streams packed table bytes (3 bytes give two
//            entries, restart_load marks the first byte of a table), START
//            sets the first cluster and file length, NEXT asks for a chunk.
//   out_ch : one descriptor per NEXT request while a walk is active: cluster,
//            byte address (data_base + cluster * 512, mod 2^32), chunk length,
//            last flag and chain error flag.
//   cfg_we/cfg_wdata : write data_base while the block is idle.
// Sequence:
//   LOAD and START are taken while idle. NEXT issues the table read of the
//   current cluster when the request is taken; the link state then takes
//   the link from the registered table RAM output and loads the output
//   register once the output slot is free. No request is taken in the link
//   state, so a new chunk request waits until the older one is loaded.
// Reset: control state clears, data_base returns to 0x3e00. The table RAM
//   is not cleared; entries read before being loaded are undefined.
// Stalls: a held descriptor does not block LOAD or START requests. A NEXT
//   request taken while a descriptor waits sits in the link state, with
//   in_ch.ready low, until the receiver takes the older descriptor.
// ---------------------------------------------------------------------------
`include "fat12_cluster_chain_walker_assert.svh"

module fat12_cluster_chain_walker
  import fccw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  fccw_in_if.sink           in_ch,
  fccw_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  // -------------------------------------------------------------------------
  // State
  // -------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   data_base_r;
  load_phase_t         phase_r, phase_nxt;
  logic [HELD_W-1:0]   held_r, held_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [LINK_W-1:0]   cur_clus_r, cur_clus_nxt;
  logic [SIZE_W-1:0]   remain_r, remain_nxt;
  logic                active_r, active_nxt;

  // chunk decided at request time, emitted in the link state
  logic [LEN_W-1:0]    pend_len_r, pend_len_nxt;
  logic                pend_last_r, pend_last_nxt;
  logic                pend_err_r, pend_err_nxt;
  logic                pend_follow_r, pend_follow_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [LINK_W-1:0]   out_clus_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [LEN_W-1:0]    out_len_r;
  logic                out_last_r;
  logic                out_err_r;

  // -------------------------------------------------------------------------
  // Handshake decode
  // -------------------------------------------------------------------------
  logic  in_ready;
  logic  out_load;
  logic  slot_free;
  logic  in_acc;
  logic  acc_load, acc_start, acc_next;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_acc    = in_ch.valid && in_ready;
  assign acc_load  = in_acc && (kind_t'(in_ch.kind) == KIND_LOAD);
  assign acc_start = in_acc && (kind_t'(in_ch.kind) == KIND_START);
  assign acc_next  = in_acc && (kind_t'(in_ch.kind) == KIND_NEXT) && active_r;

  // -------------------------------------------------------------------------
  // Controller: next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_next) begin
          state_nxt = ST_LINK;
        end
      end
      ST_LINK: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller: outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_LINK: out_load = slot_free;
      default: in_ready = 1'b0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Table load: unpack three bytes into two 12-bit entries
  // -------------------------------------------------------------------------
  load_phase_t         phase_eff;
  logic [POS_W-1:0]    pos_eff;
  logic [POS_W:0]      pos_plus1;
  logic [POS_W:0]      pos_plus2;
  logic                wr_en;
  logic [TBL_AW-1:0]   wr_addr;
  logic [LINK_W-1:0]   wr_data;

  assign phase_eff = in_ch.restart_load ? LD_FIRST : phase_r;
  assign pos_eff   = in_ch.restart_load ? '0 : pos_r;
  assign pos_plus1 = {1'b0, pos_eff} + (POS_W+1)'(1);
  assign pos_plus2 = {1'b0, pos_eff} + (POS_W+1)'(2);

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    pos_nxt   = pos_r;
    wr_en     = 1'b0;
    wr_addr   = pos_eff[TBL_AW-1:0];
    wr_data   = {in_ch.packed_byte[3:0], held_r[7:0]};
    if (acc_load) begin
      pos_nxt = pos_eff;
      unique case (phase_eff)
        LD_FIRST: begin
          held_nxt  = {{(HELD_W-BYTE_W){1'b0}}, in_ch.packed_byte};
          phase_nxt = LD_SECOND;
        end
        LD_SECOND: begin
          held_nxt  = {in_ch.packed_byte, held_r[7:0]};
          wr_en     = ({1'b0, pos_eff} < (POS_W+1)'(TABLE_ENTRIES));
          phase_nxt = LD_THIRD;
        end
        default: begin
          // third byte: second entry of the group
          wr_addr   = pos_plus1[TBL_AW-1:0];
          wr_data   = {in_ch.packed_byte, held_r[15:12]};
          wr_en     = (pos_plus1 < (POS_W+1)'(TABLE_ENTRIES));
          if ({1'b0, pos_eff} < (POS_W+1)'(TABLE_ENTRIES)) begin
            pos_nxt = pos_plus2[POS_W-1:0];
          end
          held_nxt  = '0;
          phase_nxt = LD_FIRST;
        end
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Table RAM: written by loads, read once per chunk request
  // -------------------------------------------------------------------------
  logic [LINK_W-1:0] link_rd;

  fccw_ram #(
    .WIDTH (LINK_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (acc_next),
    .raddr (cur_clus_r[TBL_AW-1:0]),
    .rdata (link_rd)
  );

  // -------------------------------------------------------------------------
  // Walk control
  // -------------------------------------------------------------------------
  logic clus_in_table;
  logic short_chunk;

  assign clus_in_table = ({1'b0, cur_clus_r} < (LINK_W+1)'(TABLE_ENTRIES));
  assign short_chunk   = (remain_r <= SIZE_W'(CLUSTER_BYTES));

  always_comb begin
    cur_clus_nxt    = cur_clus_r;
    remain_nxt      = remain_r;
    active_nxt      = active_r;
    pend_len_nxt    = pend_len_r;
    pend_last_nxt   = pend_last_r;
    pend_err_nxt    = pend_err_r;
    pend_follow_nxt = pend_follow_r;
    if (acc_start) begin
      cur_clus_nxt = in_ch.start_cluster;
      remain_nxt   = in_ch.byte_size;
      active_nxt   = 1'b1;
    end else if (acc_next) begin
      if (short_chunk) begin
        // final chunk carries whatever is left, possibly nothing
        pend_len_nxt    = remain_r[LEN_W-1:0];
        pend_last_nxt   = 1'b1;
        pend_err_nxt    = 1'b0;
        pend_follow_nxt = 1'b0;
        remain_nxt      = '0;
        active_nxt      = 1'b0;
      end else begin
        pend_len_nxt    = LEN_W'(CLUSTER_BYTES);
        remain_nxt      = remain_r - SIZE_W'(CLUSTER_BYTES);
        pend_follow_nxt = clus_in_table;
        pend_last_nxt   = !clus_in_table;
        pend_err_nxt    = !clus_in_table;
        if (!clus_in_table) begin
          active_nxt = 1'b0;
        end
      end
    end else if (out_load && pend_follow_r) begin
      cur_clus_nxt = link_rd;
    end
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      data_base_r   <= DATA_BASE_RESET;
      phase_r       <= LD_FIRST;
      held_r        <= '0;
      pos_r         <= '0;
      cur_clus_r    <= '0;
      remain_r      <= '0;
      active_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      pend_follow_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_we) begin
        data_base_r <= cfg_wdata;
      end
      phase_r       <= phase_nxt;
      held_r        <= held_nxt;
      pos_r         <= pos_nxt;
      cur_clus_r    <= cur_clus_nxt;
      remain_r      <= remain_nxt;
      active_r      <= active_nxt;
      out_valid_r   <= out_valid_nxt;
      pend_follow_r <= pend_follow_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_len_r  <= pend_len_nxt;
    pend_last_r <= pend_last_nxt;
    pend_err_r  <= pend_err_nxt;
    if (out_load) begin
      out_clus_r <= cur_clus_r;
      out_addr_r <= data_base_r + ADDR_W'({cur_clus_r, {CLUSTER_SHIFT{1'b0}}});
      out_len_r  <= pend_len_r;
      out_last_r <= pend_last_r;
      out_err_r  <= pend_err_r;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.cluster      = out_clus_r;
  assign out_ch.byte_address = out_addr_r;
  assign out_ch.chunk_length = out_len_r;
  assign out_ch.last_chunk   = out_last_r;
  assign out_ch.chain_error  = out_err_r;

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  `FCCW_ASSERT_NEXT(a_next_enters_link, acc_next, state_r == ST_LINK,
    "chunk request did not enter the link state")
  `FCCW_ASSERT_NOW(a_err_is_last, out_valid_r && out_err_r, out_last_r,
    "chain error without last flag")
  `FCCW_ASSERT_NOW(a_len_bound, out_valid_r, out_len_r <= LEN_W'(CLUSTER_BYTES),
    "chunk length beyond one cluster")
  `FCCW_ASSERT_NEXT(a_link_holds_rd, (state_r == ST_LINK) && !slot_free && pend_follow_r,
    $stable(link_rd) && (state_r == ST_LINK),
    "link read lost while descriptor stalled")

endmodule
